>>> rtl/spdg_pkg.sv
// ----------------------------------------------------------------------------
// Source pan and distance gain: shared package
// Widths, lane indexes, register codes and the payload records that travel
// alongside the arithmetic through the pipelined units.
// ----------------------------------------------------------------------------
package spdg_pkg;

    localparam int POS_W   = 24;             // position field width
    localparam int DIFF_W  = POS_W + 1;      // exact source minus listener
    localparam int FWD_W   = 16;             // forward component width
    localparam int SQ_W    = 2 * DIFF_W;     // squared distance width
    localparam int K_W     = 4;              // scale shift width
    localparam int R_W     = 16;             // scaled direction component
    localparam int PROD_W  = 2 * R_W;        // 16 x 16 product
    localparam int NUM_W   = PROD_W + 1;     // pan numerator, signed
    localparam int RAD_W   = 64;             // radicand width
    localparam int ROOT_W  = RAD_W / 2;      // root width
    localparam int D_W     = DIFF_W;         // distance width
    localparam int REF_W   = 23;
    localparam int MAX_W   = 24;
    localparam int ROLL_W  = 16;
    localparam int CFG_W   = 24;             // widest register
    localparam int CIDX_W  = 2;
    localparam int RPROD_W = ROLL_W + D_W;   // rolloff times excess distance
    localparam int Q_W     = 17;             // quotient bits
    localparam int DVD_W   = 47;             // dividend width
    localparam int DVS_W   = RPROD_W + 1;    // divisor width
    localparam int LANES   = 2;
    localparam int LANE_DIST = 0;
    localparam int LANE_PAN  = 1;
    localparam int OUT_W   = 16;

    localparam logic [REF_W-1:0]  REF_FLOOR     = REF_W'(3);
    localparam logic [REF_W-1:0]  REF_DIST_RST  = REF_W'(256);
    localparam logic [MAX_W-1:0]  MAX_DIST_RST  = MAX_W'(25600);
    localparam logic [ROLL_W-1:0] ROLLOFF_RST   = ROLL_W'(256);

    typedef enum logic [CIDX_W-1:0] {
        CFG_REF_DIST = 2'd0,
        CFG_MAX_DIST = 2'd1,
        CFG_ROLLOFF  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic                    pan_zero;
    } sqrt_pay_t;

    typedef struct packed {
        logic neg;
        logic pan_zero;
        logic far;
    } div_pay_t;

endpackage

>>> rtl/source_pan_and_distance_gain.sv
// ----------------------------------------------------------------------------
// Source pan and distance gain
// Pipeline: 6 front stages, 32 square-root stages, 3 preparation stages,
// 17 divider stages and an output register.
// Throughput: one item per cycle while the skid register is empty; the whole pipeline holds while it is full.
// Reset: asynchronous active low; clears all valid bits and loads the
// registers with ref_dist 256, max_dist 25600 and rolloff 256.
// ----------------------------------------------------------------------------
module source_pan_and_distance_gain
    import spdg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Input stream.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // src_x, src_y, src_z, cam_x, cam_y, cam_z (24 bits each),
    // fwd_x, fwd_y, fwd_z (16 bits each), from the lowest bit up.
    input  logic [191:0]       s_axis_tdata,
    // Output stream.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // pan (16 bits), gain (16 bits), from the lowest bit up.
    output logic [31:0]        m_axis_tdata,
    // Configuration write channel.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    // Configuration registers. The user must see that they are written only while
    // the pipeline is empty; the block itself does not enforce it. So every stage may read them directly.
    logic [REF_W-1:0]  ref_dist_reg;
    logic [MAX_W-1:0]  max_dist_reg;
    logic [ROLL_W-1:0] rolloff_reg;

    // The whole pipeline moves on one enable. The output side has an output
    // register plus a skid register, so the enable depends only on whether
    // the skid register is full and never on m_axis_tready directly.
    logic en;

    logic                          fr_vld;
    logic [LANES-1:0][RAD_W-1:0]   fr_rad;
    sqrt_pay_t                     fr_pay;

    logic                          sq_vld;
    logic [LANES-1:0][ROOT_W-1:0]  sq_root;
    sqrt_pay_t                     sq_pay;

    logic                          pr_vld;
    logic [LANES-1:0][DVD_W-1:0]   pr_dvd;
    logic [LANES-1:0][DVS_W-1:0]   pr_dvs;
    div_pay_t                      pr_pay;

    logic                          dv_vld;
    logic [LANES-1:0][Q_W-1:0]     dv_quot;
    div_pay_t                      dv_pay;

    logic [Q_W-1:0]    gq, pq;
    logic [OUT_W-1:0]  pan_next, gain_next;
    logic              push;

    logic              out_vld_reg;
    logic [31:0]       out_data_reg;
    logic              skid_vld_reg;
    logic [31:0]       skid_data_reg;

    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_dist_reg <= REF_DIST_RST;
            max_dist_reg <= MAX_DIST_RST;
            rolloff_reg  <= ROLLOFF_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_REF_DIST: ref_dist_reg <= cfg_data[REF_W-1:0];
                CFG_MAX_DIST: max_dist_reg <= cfg_data[MAX_W-1:0];
                CFG_ROLLOFF:  rolloff_reg  <= cfg_data[ROLL_W-1:0];
                default:      ;
            endcase
        end
    end

    // Distance squares, scaled direction, pan numerator and pan radicand.
    spdg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_axis_tvalid),
        .src_x   (s_axis_tdata[23:0]),
        .src_y   (s_axis_tdata[47:24]),
        .src_z   (s_axis_tdata[71:48]),
        .cam_x   (s_axis_tdata[95:72]),
        .cam_y   (s_axis_tdata[119:96]),
        .cam_z   (s_axis_tdata[143:120]),
        .fwd_x   (s_axis_tdata[159:144]),
        .fwd_z   (s_axis_tdata[191:176]),
        .out_vld (fr_vld),
        .rad     (fr_rad),
        .out_pay (fr_pay)
    );

    // The distance root and the pan normalization root run side by side.
    spdg_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (fr_vld),
        .rad     (fr_rad),
        .in_pay  (fr_pay),
        .out_vld (sq_vld),
        .root    (sq_root),
        .out_pay (sq_pay)
    );

    // Gain denominator through the rolloff multiply, pan magnitude and sign.
    spdg_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ref_dist (ref_dist_reg),
        .max_dist (max_dist_reg),
        .rolloff  (rolloff_reg),
        .in_vld   (sq_vld),
        .root     (sq_root),
        .in_pay   (sq_pay),
        .out_vld  (pr_vld),
        .dvd      (pr_dvd),
        .dvs      (pr_dvs),
        .out_pay  (pr_pay)
    );

    // Both quotients stay below 2^17, so seventeen stages suffice.
    spdg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (pr_vld),
        .dvd     (pr_dvd),
        .dvs     (pr_dvs),
        .in_pay  (pr_pay),
        .out_vld (dv_vld),
        .quot    (dv_quot),
        .out_pay (dv_pay)
    );

    // Final saturation. The pan quotient never exceeds 32768, which is full
    // scale; the positive side clips to 32767 and the negative side keeps
    // -32768. The gain quotient reaches 65536 only at unity gain.
    always_comb
    begin
        gq = dv_quot[LANE_DIST];
        pq = dv_quot[LANE_PAN];

        if (dv_pay.far)
        begin
            gain_next = '0;
        end
        else if (gq[Q_W-1])
        begin
            gain_next = '1;
        end
        else
        begin
            gain_next = gq[OUT_W-1:0];
        end

        priority if (dv_pay.pan_zero)
        begin
            pan_next = '0;
        end
        else if (pq[Q_W-1] || pq[Q_W-2])
        begin
            pan_next = dv_pay.neg ? 16'h8000 : 16'h7FFF;
        end
        else
        begin
            pan_next = dv_pay.neg ? OUT_W'(-pq) : pq[OUT_W-1:0];
        end
    end

    assign push = en && dv_vld;

    // Output register with a skid register behind it. A finished item lands
    // in the skid register only when the output register holds an item that
    // is not being taken; the pipeline then holds until the skid drains.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_reg <= 1'b1;
                end
                else
                begin
                    skid_vld_reg <= 1'b1;
                end
            end
            else if (out_vld_reg && m_axis_tready)
            begin
                out_vld_reg  <= skid_vld_reg;
                skid_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!out_vld_reg || m_axis_tready)
            begin
                out_data_reg <= {gain_next, pan_next};
            end
            else
            begin
                skid_data_reg <= {gain_next, pan_next};
            end
        end
        else if (out_vld_reg && m_axis_tready && skid_vld_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/spdg_front.sv
// ----------------------------------------------------------------------------
// Source pan and distance gain: front arithmetic
// Six register stages that form the squared distance, the scaled direction,
// the pan numerator and the product that feeds the pan normalization root.
// ----------------------------------------------------------------------------
module spdg_front
    import spdg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic signed [POS_W-1:0]       src_x,
    input  logic signed [POS_W-1:0]       src_y,
    input  logic signed [POS_W-1:0]       src_z,
    input  logic signed [POS_W-1:0]       cam_x,
    input  logic signed [POS_W-1:0]       cam_y,
    input  logic signed [POS_W-1:0]       cam_z,
    input  logic signed [FWD_W-1:0]       fwd_x,
    input  logic signed [FWD_W-1:0]       fwd_z,
    output logic                          out_vld,
    output logic [LANES-1:0][RAD_W-1:0]   rad,
    output sqrt_pay_t                     out_pay
);

    logic [5:0] vld_reg;

    // Stage 1: differences.
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [FWD_W-1:0]  fx1_reg, fz1_reg;

    // Stage 2: magnitudes, squares and scale shift.
    logic [DIFF_W-1:0]        ax, ay, az, mx;
    logic [K_W-1:0]           k_next;
    logic [DIFF_W-1:0]        ax_reg, ay_reg, az_reg;
    logic [2:0]               sgn_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic [PROD_W-1:0]        fsqx_reg, fsqz_reg;
    logic [K_W-1:0]           k_reg;
    logic signed [FWD_W-1:0]  fx2_reg, fz2_reg;

    // Stage 3: sums and scaled direction.
    logic [SQ_W-1:0]          s3_reg;
    logic [PROD_W-1:0]        f3_reg;
    logic signed [R_W-1:0]    rx_reg, ry_reg, rz_reg;
    logic signed [FWD_W-1:0]  fx3_reg, fz3_reg;
    logic [R_W-2:0]           mgx, mgy, mgz;

    // Stage 4: products.
    logic signed [PROD_W-1:0] pz_reg, px_reg;
    logic [PROD_W-1:0]        rsqx_reg, rsqy_reg, rsqz_reg;
    logic [SQ_W-1:0]          s4_reg;
    logic [PROD_W-1:0]        f4_reg;
    logic                     pz4_reg;

    // Stage 5: numerator and squared length.
    logic signed [NUM_W-1:0]  num5_reg;
    logic [PROD_W-1:0]        sr_reg;
    logic [SQ_W-1:0]          s5_reg;
    logic [PROD_W-1:0]        f5_reg;
    logic                     pz5_reg;

    // Stage 6: pan radicand.
    logic [RAD_W-1:0]         p_reg;
    logic [SQ_W-1:0]          s6_reg;
    logic signed [NUM_W-1:0]  num6_reg;
    logic                     pz6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_vld};
        end
    end

    always_comb
    begin
        ax = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
        ay = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
        az = dz_reg[DIFF_W-1] ? DIFF_W'(-dz_reg) : DIFF_W'(dz_reg);
        mx = ax;
        if (ay > mx)
        begin
            mx = ay;
        end
        if (az > mx)
        begin
            mx = az;
        end
        // Least shift that brings the largest magnitude below 2^15.
        k_next = '0;
        for (int b = R_W - 1; b < DIFF_W; b++)
        begin
            if (mx[b])
            begin
                k_next = K_W'(b - (R_W - 2));
            end
        end
    end

    always_comb
    begin
        mgx = (R_W-1)'(ax_reg >> k_reg);
        mgy = (R_W-1)'(ay_reg >> k_reg);
        mgz = (R_W-1)'(az_reg >> k_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= DIFF_W'(src_x) - DIFF_W'(cam_x);
            dy_reg   <= DIFF_W'(src_y) - DIFF_W'(cam_y);
            dz_reg   <= DIFF_W'(src_z) - DIFF_W'(cam_z);
            fx1_reg  <= fwd_x;
            fz1_reg  <= fwd_z;

            ax_reg   <= ax;
            ay_reg   <= ay;
            az_reg   <= az;
            sgn_reg  <= {dz_reg[DIFF_W-1], dy_reg[DIFF_W-1], dx_reg[DIFF_W-1]};
            sqx_reg  <= ax * ax;
            sqy_reg  <= ay * ay;
            sqz_reg  <= az * az;
            fsqx_reg <= PROD_W'(fx1_reg * fx1_reg);
            fsqz_reg <= PROD_W'(fz1_reg * fz1_reg);
            k_reg    <= k_next;
            fx2_reg  <= fx1_reg;
            fz2_reg  <= fz1_reg;

            s3_reg   <= sqx_reg + sqy_reg + sqz_reg;
            f3_reg   <= fsqx_reg + fsqz_reg;
            rx_reg   <= sgn_reg[0] ? -$signed({1'b0, mgx}) : $signed({1'b0, mgx});
            ry_reg   <= sgn_reg[1] ? -$signed({1'b0, mgy}) : $signed({1'b0, mgy});
            rz_reg   <= sgn_reg[2] ? -$signed({1'b0, mgz}) : $signed({1'b0, mgz});
            fx3_reg  <= fx2_reg;
            fz3_reg  <= fz2_reg;

            pz_reg   <= PROD_W'(rz_reg * fx3_reg);
            px_reg   <= PROD_W'(rx_reg * fz3_reg);
            rsqx_reg <= PROD_W'(rx_reg * rx_reg);
            rsqy_reg <= PROD_W'(ry_reg * ry_reg);
            rsqz_reg <= PROD_W'(rz_reg * rz_reg);
            s4_reg   <= s3_reg;
            f4_reg   <= f3_reg;
            pz4_reg  <= (s3_reg == '0) || (f3_reg == '0);

            num5_reg <= NUM_W'(pz_reg) - NUM_W'(px_reg);
            sr_reg   <= rsqx_reg + rsqy_reg + rsqz_reg;
            s5_reg   <= s4_reg;
            f5_reg   <= f4_reg;
            pz5_reg  <= pz4_reg;

            p_reg    <= sr_reg * f5_reg;
            s6_reg   <= s5_reg;
            num6_reg <= num5_reg;
            pz6_reg  <= pz5_reg;
        end
    end

    assign out_vld          = vld_reg[5];
    assign rad[LANE_DIST]   = RAD_W'(s6_reg);
    assign rad[LANE_PAN]    = p_reg;
    assign out_pay.num      = num6_reg;
    assign out_pay.pan_zero = pz6_reg;

endmodule

>>> rtl/spdg_isqrt.sv
// ----------------------------------------------------------------------------
// Source pan and distance gain: pipelined square root
// One root bit per register stage for each lane, floor of the square root.
// ----------------------------------------------------------------------------
module spdg_isqrt
    import spdg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [LANES-1:0][RAD_W-1:0]   rad,
    input  sqrt_pay_t                     in_pay,
    output logic                          out_vld,
    output logic [LANES-1:0][ROOT_W-1:0]  root,
    output sqrt_pay_t                     out_pay
);

    localparam int TRIAL_W = RAD_W + 1;

    logic [LANES-1:0][RAD_W-1:0]  rem_reg  [ROOT_W];
    logic [LANES-1:0][ROOT_W-1:0] root_reg [ROOT_W];
    logic                         vld_reg  [ROOT_W];
    sqrt_pay_t                    pay_reg  [ROOT_W];

    for (genvar st = 0; st < ROOT_W; st++)
    begin : g_stage
        localparam int BIT = ROOT_W - 1 - st;

        logic [LANES-1:0][RAD_W-1:0]   rem_in;
        logic [LANES-1:0][ROOT_W-1:0]  root_in;
        logic                          vld_in;
        sqrt_pay_t                     pay_in;
        logic [LANES-1:0][TRIAL_W-1:0] trial;
        logic [LANES-1:0][RAD_W-1:0]   rem_next;
        logic [LANES-1:0][ROOT_W-1:0]  root_next;

        if (st == 0)
        begin : g_head
            assign rem_in  = rad;
            assign root_in = '0;
            assign vld_in  = in_vld;
            assign pay_in  = in_pay;
        end
        else
        begin : g_body
            assign rem_in  = rem_reg[st-1];
            assign root_in = root_reg[st-1];
            assign vld_in  = vld_reg[st-1];
            assign pay_in  = pay_reg[st-1];
        end

        // Remainder holds the radicand minus the square of the partial root.
        always_comb
        begin
            for (int ln = 0; ln < LANES; ln++)
            begin
                trial[ln] = (TRIAL_W'(root_in[ln]) << (BIT + 1))
                          + (TRIAL_W'(1) << (2 * BIT));
                if ({1'b0, rem_in[ln]} >= trial[ln])
                begin
                    rem_next[ln]  = rem_in[ln] - trial[ln][RAD_W-1:0];
                    root_next[ln] = root_in[ln] | (ROOT_W'(1) << BIT);
                end
                else
                begin
                    rem_next[ln]  = rem_in[ln];
                    root_next[ln] = root_in[ln];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[st] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[st] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[st]  <= rem_next;
                root_reg[st] <= root_next;
                pay_reg[st]  <= pay_in;
            end
        end
    end

    assign out_vld = vld_reg[ROOT_W-1];
    assign root    = root_reg[ROOT_W-1];
    assign out_pay = pay_reg[ROOT_W-1];

endmodule

>>> rtl/spdg_prep.sv
// ----------------------------------------------------------------------------
// Source pan and distance gain: divider preparation
// Three register stages that turn the two roots into the dividends and
// divisors of the gain and pan quotients.
// ----------------------------------------------------------------------------
module spdg_prep
    import spdg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [REF_W-1:0]              ref_dist,
    input  logic [MAX_W-1:0]              max_dist,
    input  logic [ROLL_W-1:0]             rolloff,
    input  logic                          in_vld,
    input  logic [LANES-1:0][ROOT_W-1:0]  root,
    input  sqrt_pay_t                     in_pay,
    output logic                          out_vld,
    output logic [LANES-1:0][DVD_W-1:0]   dvd,
    output logic [LANES-1:0][DVS_W-1:0]   dvs,
    output div_pay_t                      out_pay
);

    logic [REF_W-1:0]  r_eff;
    logic [MAX_W-1:0]  m_eff;
    logic [D_W-1:0]    dist_root;
    logic [NUM_W-1:0]  num_mag;

    logic [2:0]         vld_reg;
    logic [D_W-1:0]     e_reg;
    logic [ROOT_W-1:0]  nmag1_reg, nmag2_reg;
    logic [ROOT_W-1:0]  rootp1_reg, rootp2_reg;
    logic [RPROD_W-1:0] rprod_reg;
    div_pay_t           pay1_reg, pay2_reg, pay3_reg;
    logic [LANES-1:0][DVD_W-1:0] dvd_reg;
    logic [LANES-1:0][DVS_W-1:0] dvs_reg;

    // The reference distance has a floor and the maximum never sits below it.
    always_comb
    begin
        r_eff     = (ref_dist < REF_FLOOR) ? REF_FLOOR : ref_dist;
        m_eff     = (max_dist < MAX_W'(r_eff)) ? MAX_W'(r_eff) : max_dist;
        dist_root = root[LANE_DIST][D_W-1:0];
        num_mag   = in_pay.num[NUM_W-1] ? NUM_W'(-in_pay.num) : NUM_W'(in_pay.num);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg             <= (dist_root > D_W'(r_eff)) ? dist_root - D_W'(r_eff) : '0;
            nmag1_reg         <= num_mag[ROOT_W-1:0];
            rootp1_reg        <= root[LANE_PAN];
            pay1_reg.neg      <= in_pay.num[NUM_W-1];
            pay1_reg.pan_zero <= in_pay.pan_zero || (root[LANE_PAN] == '0);
            pay1_reg.far      <= root[LANE_DIST] >= ROOT_W'(m_eff);

            rprod_reg         <= rolloff * e_reg;
            nmag2_reg         <= nmag1_reg;
            rootp2_reg        <= rootp1_reg;
            pay2_reg          <= pay1_reg;

            dvd_reg[LANE_DIST] <= DVD_W'(r_eff) << 24;
            dvs_reg[LANE_DIST] <= (DVS_W'(r_eff) << 8) + DVS_W'(rprod_reg);
            dvd_reg[LANE_PAN]  <= DVD_W'(nmag2_reg) << 15;
            dvs_reg[LANE_PAN]  <= DVS_W'(rootp2_reg);
            pay3_reg           <= pay2_reg;
        end
    end

    assign out_vld = vld_reg[2];
    assign dvd     = dvd_reg;
    assign dvs     = dvs_reg;
    assign out_pay = pay3_reg;

endmodule

>>> rtl/spdg_div.sv
// ----------------------------------------------------------------------------
// Source pan and distance gain: pipelined divider
// Restoring division, one quotient bit per register stage for each lane.
// ----------------------------------------------------------------------------
module spdg_div
    import spdg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [LANES-1:0][DVD_W-1:0]   dvd,
    input  logic [LANES-1:0][DVS_W-1:0]   dvs,
    input  div_pay_t                      in_pay,
    output logic                          out_vld,
    output logic [LANES-1:0][Q_W-1:0]     quot,
    output div_pay_t                      out_pay
);

    localparam int CMP_W = DVS_W + Q_W;

    logic [LANES-1:0][DVD_W-1:0] rem_reg [Q_W];
    logic [LANES-1:0][DVS_W-1:0] dvs_reg [Q_W];
    logic [LANES-1:0][Q_W-1:0]   q_reg   [Q_W];
    logic                        vld_reg [Q_W];
    div_pay_t                    pay_reg [Q_W];

    for (genvar st = 0; st < Q_W; st++)
    begin : g_stage
        localparam int BIT = Q_W - 1 - st;

        logic [LANES-1:0][DVD_W-1:0] rem_in;
        logic [LANES-1:0][DVS_W-1:0] dvs_in;
        logic [LANES-1:0][Q_W-1:0]   q_in;
        logic                        vld_in;
        div_pay_t                    pay_in;
        logic [LANES-1:0][CMP_W-1:0] cand;
        logic [LANES-1:0][DVD_W-1:0] rem_next;
        logic [LANES-1:0][Q_W-1:0]   q_next;

        if (st == 0)
        begin : g_head
            assign rem_in = dvd;
            assign dvs_in = dvs;
            assign q_in   = '0;
            assign vld_in = in_vld;
            assign pay_in = in_pay;
        end
        else
        begin : g_body
            assign rem_in = rem_reg[st-1];
            assign dvs_in = dvs_reg[st-1];
            assign q_in   = q_reg[st-1];
            assign vld_in = vld_reg[st-1];
            assign pay_in = pay_reg[st-1];
        end

        always_comb
        begin
            for (int ln = 0; ln < LANES; ln++)
            begin
                cand[ln] = CMP_W'(dvs_in[ln]) << BIT;
                if (CMP_W'(rem_in[ln]) >= cand[ln])
                begin
                    rem_next[ln] = rem_in[ln] - cand[ln][DVD_W-1:0];
                    q_next[ln]   = q_in[ln] | (Q_W'(1) << BIT);
                end
                else
                begin
                    rem_next[ln] = rem_in[ln];
                    q_next[ln]   = q_in[ln];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[st] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[st] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[st] <= rem_next;
                dvs_reg[st] <= dvs_in;
                q_reg[st]   <= q_next;
                pay_reg[st] <= pay_in;
            end
        end
    end

    assign out_vld = vld_reg[Q_W-1];
    assign quot    = q_reg[Q_W-1];
    assign out_pay = pay_reg[Q_W-1];

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source pan and distance gain testbench
// Streams listener/source geometry through the block under random stalls on
// both sides, predicts pan and gain per item and compares each output transfer
// in order. Registers are rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module tb;
    import spdg_pkg::*;

    typedef struct packed {
        logic signed [15:0] fz, fy, fx;
        logic signed [23:0] cz, cy, cx, sz, sy, sx;
    } geom_t;

    typedef struct packed {
        logic [15:0]        gain;
        logic signed [15:0] pan;
    } mix_t;

    logic clk = 0;
    logic rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // Shadow copy of the block's registers, used by the predictor.
    logic [REF_W-1:0]  ref_reg;
    logic [MAX_W-1:0]  max_reg;
    logic [ROLL_W-1:0] roll_reg;

    geom_t pending_q[$];
    mix_t  mix_expected_q[$];
    int    mismatches = 0;
    int    send_gap = 0;
    int    recv_gap = 0;
    bit    calm = 0;        // no idling in the closing part of the run
    bit    sender_hold = 0;

    source_pan_and_distance_gain dut (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs64(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint shrink_by(longint x, int k);
        longint m;
        m = longint'(abs64(x) >> k);
        return x < 0 ? -m : m;
    endfunction

    // Pan and gain for one geometry item under the current registers.
    function automatic mix_t predict_mix(geom_t g);
        longint dx, dy, dz, fx, fz, rx, ry, rz, num, p;
        longint unsigned s, dist_m, f, mx, sr, root, r, m, e, den, gn;
        int k;
        mix_t o;
        dx = longint'(g.sx) - longint'(g.cx);
        dy = longint'(g.sy) - longint'(g.cy);
        dz = longint'(g.sz) - longint'(g.cz);
        fx = g.fx;
        fz = g.fz;
        s = abs64(dx) * abs64(dx) + abs64(dy) * abs64(dy) + abs64(dz) * abs64(dz);
        dist_m = int_sqrt(s);
        f = abs64(fx) * abs64(fx) + abs64(fz) * abs64(fz);
        p = 0;
        // Source at the listener or vertical/zero forward both leave pan at 0.
        if (s != 0 && f != 0)
        begin
            mx = abs64(dx);
            if (abs64(dy) > mx) mx = abs64(dy);
            if (abs64(dz) > mx) mx = abs64(dz);
            k = 0;
            while ((mx >> k) >= 32768) k++;
            rx = shrink_by(dx, k);
            ry = shrink_by(dy, k);
            rz = shrink_by(dz, k);
            num = rz * fx - rx * fz;
            sr = longint'(rx * rx + ry * ry + rz * rz);
            root = int_sqrt(sr * f);
            if (root != 0)
            begin
                p = (num * 32768) / longint'(root);
                if (p > 32767) p = 32767;
                if (p < -32768) p = -32768;
            end
        end
        r = ref_reg < 3 ? 3 : ref_reg;
        m = max_reg < r ? r : max_reg;
        if (dist_m >= m)
            gn = 0;
        else
        begin
            e = dist_m > r ? dist_m - r : 0;
            den = r * 256 + roll_reg * e;
            gn = (r << 24) / den;
            if (gn > 65535) gn = 65535;
        end
        o.pan = p[15:0];
        o.gain = gn[15:0];
        return o;
    endfunction

    // Driver: one transfer per accepted item, random idle bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                mix_expected_q.push_back(predict_mix(geom_t'(s_axis_tdata)));
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 0;
                end
                else if (pending_q.size() > 0 && !sender_hold)
                begin
                    s_axis_tdata <= pending_q.pop_front();
                    s_axis_tvalid <= 1;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 12);
                end
                else
                    s_axis_tvalid <= 0;
            end
        end
    end

    // Monitor: compare each output transfer with the oldest prediction.
    always @(posedge clk)
    begin
        mix_t got, want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (mix_expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output pan=%0d gain=%0d", got.pan, got.gain);
                end
                else
                begin
                    want = mix_expected_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: pan exp %0d got %0d, gain exp %0d got %0d",
                                     want.pan, got.pan, want.gain, got.gain);
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 0;
            end
            else
            begin
                m_axis_tready <= 1;
                if (!calm && $urandom_range(0, 9) == 0)
                    recv_gap <= $urandom_range(1, 12);
            end
        end
    end

    function automatic logic signed [23:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 2047) - 1024);
            1: return 24'($urandom_range(0, 200000) - 100000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_fwd();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return '0;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic geom_t rand_geom();
        geom_t g;
        g.sx = rand_pos(); g.sy = rand_pos(); g.sz = rand_pos();
        g.cx = rand_pos(); g.cy = rand_pos(); g.cz = rand_pos();
        g.fx = rand_fwd(); g.fy = rand_fwd(); g.fz = rand_fwd();
        if ($urandom_range(0, 15) == 0)
        begin
            g.sx = g.cx; g.sy = g.cy; g.sz = g.cz;
        end
        return g;
    endfunction

    function automatic geom_t mk(int sx, int sy, int sz, int cx, int cy, int cz,
                                 int fx, int fy, int fz);
        geom_t g;
        g.sx = 24'(sx); g.sy = 24'(sy); g.sz = 24'(sz);
        g.cx = 24'(cx); g.cy = 24'(cy); g.cz = 24'(cz);
        g.fx = 16'(fx); g.fy = 16'(fy); g.fz = 16'(fz);
        return g;
    endfunction

    // Blocks until the pipe is drained, then idles before it returns.
    task automatic wait_drained();
        while (pending_q.size() > 0 || s_axis_tvalid || mix_expected_q.size() > 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    // One register write; the channel then idles before the task returns.
    task automatic write_reg(cfg_idx_t idx, int unsigned value);
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        case (idx)
            CFG_REF_DIST: ref_reg = REF_W'(value);
            CFG_MAX_DIST: max_reg = MAX_W'(value);
            default:      roll_reg = ROLL_W'(value);
        endcase
        @(posedge clk);
    endtask

    task automatic random_phase(int n);
        repeat (n) pending_q.push_back(rand_geom());
    endtask

    initial
    begin
        ref_reg = REF_DIST_RST;
        max_reg = MAX_DIST_RST;
        roll_reg = ROLLOFF_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed items: extremes, source at listener, vertical forward.
        pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 16384, 16384));
        pending_q.push_back(mk(256, 0, 0, 0, 0, 0, 0, 0, 16384));
        pending_q.push_back(mk(-256, 0, 0, 0, 0, 0, 0, 0, 16384));
        pending_q.push_back(mk(1000, 500, 0, 0, 0, 0, 0, 16384, 0));
        pending_q.push_back(mk(1000, 500, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(8388607, 8388607, 8388607,
                               -8388608, -8388608, -8388608, -32768, -32768, -32768));
        pending_q.push_back(mk(-8388608, -8388608, -8388608,
                               8388607, 8388607, 8388607, 32767, 32767, 32767));
        pending_q.push_back(mk(0, 0, 25600, 0, 0, 0, 16384, 0, 0));
        pending_q.push_back(mk(0, 0, 25599, 0, 0, 0, -16384, 0, 0));
        pending_q.push_back(mk(300, 0, 0, 0, 0, 0, 11585, 0, 11585));
        pending_q.push_back(mk(5, 5, 5, 5, 5, 5, -1, 0, 1));
        pending_q.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, -16384));
        pending_q.push_back(mk(0, 1, 0, 0, 0, 0, 0, 0, 16384));
        random_phase(120);
        wait_drained();

        // Floors: ref below 3 and max below ref, zero rolloff.
        write_reg(CFG_REF_DIST, 0);
        write_reg(CFG_MAX_DIST, 0);
        write_reg(CFG_ROLLOFF, 0);
        pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 16384));
        pending_q.push_back(mk(2, 0, 0, 0, 0, 0, 0, 0, 16384));
        pending_q.push_back(mk(3, 0, 0, 0, 0, 0, 0, 0, 16384));
        random_phase(100);
        wait_drained();

        // Largest settings.
        write_reg(CFG_REF_DIST, 23'h7FFFFF);
        write_reg(CFG_MAX_DIST, 24'hFFFFFF);
        write_reg(CFG_ROLLOFF, 16'hFFFF);
        random_phase(100);
        wait_drained();

        // Small reference, steep rolloff.
        write_reg(CFG_REF_DIST, 3);
        write_reg(CFG_MAX_DIST, 24'hFFFFFF);
        write_reg(CFG_ROLLOFF, 16'hFFFF);
        random_phase(100);
        // Let items get into the pipe, then the sender holds off until the
        // whole pipe has drained.
        repeat (30) @(posedge clk);
        sender_hold = 1;
        while (s_axis_tvalid || mix_expected_q.size() > 0) @(posedge clk);
        sender_hold = 0;
        random_phase(50);
        wait_drained();

        // Random settings, last phase without any idling.
        write_reg(CFG_REF_DIST, $urandom_range(3, 8388607));
        write_reg(CFG_MAX_DIST, $urandom);
        write_reg(CFG_ROLLOFF, $urandom_range(0, 65535));
        random_phase(100);
        wait_drained();
        calm = 1;
        random_phase(60);
        wait_drained();

        if (mismatches == 0 && mix_expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
